### hw/rtl/hmpp_pkg.sv
`default_nettype none
package hmpp_pkg;

  localparam int unsigned HASH_W       = 64;
  localparam int unsigned KEY_BYTES    = 8;
  localparam int unsigned KEY_W        = KEY_BYTES * 8;
  localparam int unsigned LEN_W        = 4;
  localparam int unsigned VALUE_BITS   = 32;
  localparam int unsigned PERT_SHIFT   = 5;
  localparam int unsigned SIZE_W       = 4;
  localparam int unsigned ENTRIES_W    = 11;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_RSVD   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    STS_INSERTED = 3'd0,
    STS_UPDATED  = 3'd1,
    STS_HIT      = 3'd2,
    STS_MISSING  = 3'd3,
    STS_FULL     = 3'd4,
    STS_CLEARED  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_CMP,
    ST_STEP,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                  valid;
    logic [LEN_W-1:0]      len;
    logic [KEY_W-1:0]      key;
    logic [VALUE_BITS-1:0] value;
  } slot_t;

  // byte compare up to len; a shared zero byte ends the compare as a match
  function automatic logic key_eq(input logic [KEY_W-1:0] a,
                                  input logic [KEY_W-1:0] b,
                                  input logic [LEN_W-1:0] len);
    logic m;
    logic done;
    m    = 1'b1;
    done = 1'b0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (!done && (LEN_W'(i) < len)) begin
        if (a[8*i +: 8] != b[8*i +: 8]) begin
          m    = 1'b0;
          done = 1'b1;
        end else if (a[8*i +: 8] == 8'h00) begin
          done = 1'b1;
        end
      end
    end
    return m;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/hmpp_add64.sv
`default_nettype none
module hmpp_add64 (
  input  wire logic [hmpp_pkg::HASH_W-1:0] a,
  input  wire logic [hmpp_pkg::HASH_W-1:0] b,
  input  wire logic                        cin,
  output logic      [hmpp_pkg::HASH_W-1:0] sum
);

  // wrapping add, carry out dropped
  assign sum = a + b + hmpp_pkg::HASH_W'(cin);

endmodule
`default_nettype wire

### hw/rtl/hmpp_slot_ram.sv
`default_nettype none
module hmpp_slot_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire hmpp_pkg::slot_t wdata,
  input  wire logic            re,
  input  wire logic [AW-1:0]   raddr,
  output hmpp_pkg::slot_t      rdata
);

  hmpp_pkg::slot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/hash_map_perturb_probe_core.sv
// Open-addressing key/value table with perturbation probing.
// Requests enter on the in_ stream: in_tuser carries the action (insert,
// lookup, clear), in_tdata the hash, key bytes, key length and value.
// Each request gives exactly one result on the out_ stream: out_tuser is the
// status, out_tdata the looked-up value and the occupied slot count.
// The table size is set through the cfg_ APB port (register 0); the user must
// write it only while no request is in flight (the block does not enforce it).
// Insert/lookup: one request at a time. Each probe reads the slot RAM and
// compares in ST_CMP; on a miss, ST_CMP makes the first pass through the
// shared 64-bit adder and ST_STEP the second, which forms the next probe
// index (5j, then +p+1) and issues its slot RAM read.
// The next request is accepted only once this result has been taken.
// Probing stops after PROBE_LIMIT probes (full or missing).
// Clear: sweeps all MAX_SLOTS entries of the slot RAM one entry a cycle,
// then reports. At reset the same sweep runs with in_tready low and no result.
// in_tready is high only while idle; a result held by a stalled receiver
// keeps the block busy until out_tready takes it.
`default_nettype none
module hash_map_perturb_probe_core #(
  parameter int unsigned MAX_SLOTS   = 1024,
  parameter int unsigned MIN_SLOTS   = 8,
  parameter int unsigned PROBE_LIMIT = 4096
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // in_tuser: [1:0] action
  input  wire logic [1:0]   in_tuser,
  // in_tdata: [63:0] key_hash, [127:64] key_bytes, [131:128] key_length,
  //           [163:132] value_in, [167:164] zero
  input  wire logic [167:0] in_tdata,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // out_tuser: [2:0] status
  output logic [2:0]        out_tuser,
  // out_tdata: [31:0] value_out, [42:32] entries_used, [47:43] zero
  output logic [47:0]       out_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [2:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam int unsigned AW     = $clog2(MAX_SLOTS);
  localparam int unsigned CW     = $clog2(MAX_SLOTS + 1);
  localparam int unsigned NW     = $clog2(PROBE_LIMIT);
  localparam int unsigned MIN_LG = $clog2(MIN_SLOTS);
  localparam int unsigned MAX_LG = $clog2(MAX_SLOTS);
  localparam int unsigned HW     = hmpp_pkg::HASH_W;
  localparam int unsigned KW     = hmpp_pkg::KEY_W;
  localparam int unsigned LW     = hmpp_pkg::LEN_W;
  localparam int unsigned VW     = hmpp_pkg::VALUE_BITS;
  localparam int unsigned PB     = hmpp_pkg::PERT_SHIFT;

  hmpp_pkg::state_t  state_r, state_nxt;
  hmpp_pkg::action_t act_r, act_nxt;
  logic [KW-1:0]     key_r, key_nxt;
  logic [LW-1:0]     len_r, len_nxt;
  logic [VW-1:0]     val_r, val_nxt;
  logic [HW-1:0]     j_r, j_nxt;
  logic [HW-1:0]     p_r, p_nxt;
  logic [HW-1:0]     t_r, t_nxt;
  logic [NW-1:0]     n_r, n_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic              clr_report_r, clr_report_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  hmpp_pkg::status_t status_r, status_nxt;
  logic [VW-1:0]     vout_r, vout_nxt;
  logic [hmpp_pkg::SIZE_W-1:0] size_r;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  hmpp_pkg::slot_t   ram_wdata, ram_rdata;

  logic [HW-1:0]     add_a, add_b, add_sum;
  logic              add_cin;

  logic [4:0]        lg_eff;
  logic [AW:0]       one_sh;
  logic [AW-1:0]     mask;

  logic [HW-1:0]     in_hash;
  logic [LW-1:0]     in_len, in_len_sat;
  logic              hit;

  assign in_hash    = in_tdata[63:0];
  assign in_len     = in_tdata[131:128];
  assign in_len_sat = (in_len > LW'(hmpp_pkg::KEY_BYTES)) ? LW'(hmpp_pkg::KEY_BYTES) : in_len;

  // slot count saturated into [MIN_SLOTS, MAX_SLOTS]
  always_comb begin
    if ({1'b0, size_r} < 5'(MIN_LG)) begin
      lg_eff = 5'(MIN_LG);
    end else if ({1'b0, size_r} > 5'(MAX_LG)) begin
      lg_eff = 5'(MAX_LG);
    end else begin
      lg_eff = {1'b0, size_r};
    end
  end
  assign one_sh = (AW+1)'(1) << lg_eff;
  assign mask   = AW'(one_sh - 1'b1);

  hmpp_add64 u_add (
    .a   (add_a),
    .b   (add_b),
    .cin (add_cin),
    .sum (add_sum)
  );

  hmpp_slot_ram #(
    .DEPTH (MAX_SLOTS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign hit = (ram_rdata.len == len_r) && hmpp_pkg::key_eq(key_r, ram_rdata.key, len_r);

  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    key_nxt        = key_r;
    len_nxt        = len_r;
    val_nxt        = val_r;
    j_nxt          = j_r;
    p_nxt          = p_r;
    t_nxt          = t_r;
    n_nxt          = n_r;
    addr_nxt       = addr_r;
    clr_cnt_nxt    = clr_cnt_r;
    clr_report_nxt = clr_report_r;
    count_nxt      = count_r;
    status_nxt     = status_r;
    vout_nxt       = vout_r;
    ram_we         = 1'b0;
    ram_waddr      = addr_r;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = addr_r;
    add_a          = j_r << 2;
    add_b          = j_r;
    add_cin        = 1'b0;

    unique case (state_r)
      hmpp_pkg::ST_CLR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(MAX_SLOTS - 1)) begin
          if (clr_report_r) begin
            count_nxt  = '0;
            status_nxt = hmpp_pkg::STS_CLEARED;
            vout_nxt   = '0;
            state_nxt  = hmpp_pkg::ST_OUT;
          end else begin
            state_nxt = hmpp_pkg::ST_IDLE;
          end
        end
      end

      hmpp_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          act_nxt = hmpp_pkg::action_t'(in_tuser);
          key_nxt = in_tdata[127:64];
          len_nxt = in_len_sat;
          val_nxt = in_tdata[163:132];
          j_nxt   = in_hash;
          p_nxt   = in_hash;
          n_nxt   = '0;
          unique case (hmpp_pkg::action_t'(in_tuser)) inside
            hmpp_pkg::ACT_INSERT, hmpp_pkg::ACT_LOOKUP: begin
              ram_re    = 1'b1;
              ram_raddr = in_hash[AW-1:0] & mask;
              addr_nxt  = in_hash[AW-1:0] & mask;
              state_nxt = hmpp_pkg::ST_CMP;
            end
            hmpp_pkg::ACT_CLEAR: begin
              clr_cnt_nxt    = '0;
              clr_report_nxt = 1'b1;
              state_nxt      = hmpp_pkg::ST_CLR;
            end
            default: begin
              status_nxt = hmpp_pkg::STS_MISSING;
              vout_nxt   = '0;
              state_nxt  = hmpp_pkg::ST_OUT;
            end
          endcase
        end
      end

      hmpp_pkg::ST_CMP: begin
        vout_nxt = '0;
        if (!ram_rdata.valid) begin
          if (act_r == hmpp_pkg::ACT_INSERT) begin
            ram_we          = 1'b1;
            ram_wdata.valid = 1'b1;
            ram_wdata.len   = len_r;
            ram_wdata.key   = key_r;
            ram_wdata.value = val_r;
            count_nxt       = count_r + 1'b1;
            status_nxt      = hmpp_pkg::STS_INSERTED;
          end else begin
            status_nxt = hmpp_pkg::STS_MISSING;
          end
          state_nxt = hmpp_pkg::ST_OUT;
        end else if (hit) begin
          if (act_r == hmpp_pkg::ACT_INSERT) begin
            // stored key kept: it may differ past a shared zero byte
            ram_we          = 1'b1;
            ram_wdata       = ram_rdata;
            ram_wdata.value = val_r;
            status_nxt      = hmpp_pkg::STS_UPDATED;
          end else begin
            vout_nxt   = ram_rdata.value;
            status_nxt = hmpp_pkg::STS_HIT;
          end
          state_nxt = hmpp_pkg::ST_OUT;
        end else if (n_r == NW'(PROBE_LIMIT - 1)) begin
          status_nxt = (act_r == hmpp_pkg::ACT_INSERT) ? hmpp_pkg::STS_FULL
                                                       : hmpp_pkg::STS_MISSING;
          state_nxt  = hmpp_pkg::ST_OUT;
        end else begin
          // first adder pass: t = 4j + j
          t_nxt     = add_sum;
          n_nxt     = n_r + 1'b1;
          state_nxt = hmpp_pkg::ST_STEP;
        end
      end

      hmpp_pkg::ST_STEP: begin
        // second adder pass: j = 5j + p + 1, then p >>>= PB
        add_a     = t_r;
        add_b     = p_r;
        add_cin   = 1'b1;
        j_nxt     = add_sum;
        p_nxt     = {{PB{p_r[HW-1]}}, p_r[HW-1:PB]};
        ram_re    = 1'b1;
        ram_raddr = add_sum[AW-1:0] & mask;
        addr_nxt  = add_sum[AW-1:0] & mask;
        state_nxt = hmpp_pkg::ST_CMP;
      end

      hmpp_pkg::ST_OUT: begin
        if (out_tready) begin
          state_nxt = hmpp_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = hmpp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= hmpp_pkg::ST_CLR;
      clr_cnt_r    <= '0;
      clr_report_r <= 1'b0;
      count_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      clr_report_r <= clr_report_nxt;
      count_r      <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r    <= act_nxt;
    key_r    <= key_nxt;
    len_r    <= len_nxt;
    val_r    <= val_nxt;
    j_r      <= j_nxt;
    p_r      <= p_nxt;
    t_r      <= t_nxt;
    n_r      <= n_nxt;
    addr_r   <= addr_nxt;
    status_r <= status_nxt;
    vout_r   <= vout_nxt;
  end

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= hmpp_pkg::SIZE_W'(3);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2]) begin
      size_r <= cfg_pwdata[hmpp_pkg::SIZE_W-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {{(32 - hmpp_pkg::SIZE_W){1'b0}}, size_r};

  assign in_tready  = (state_r == hmpp_pkg::ST_IDLE);
  assign out_tvalid = (state_r == hmpp_pkg::ST_OUT);
  assign out_tuser  = status_r;
  assign out_tdata  = {5'd0, hmpp_pkg::ENTRIES_W'(count_r), vout_r};

endmodule
`default_nettype wire

### sim/hash_map_perturb_probe_core_test.sv
`timescale 1ns / 1ps
module hash_map_perturb_probe_core_test;

  localparam int MAX_SLOTS   = 1024;
  localparam int MIN_SLOTS   = 8;
  localparam int PROBE_LIMIT = 4096;
  localparam int POOL_DEPTH  = 32;
  localparam int CYCLE_LIMIT = 10000000;
  localparam int TAIL_CYCLES = 2100;
  localparam int PRICEY_MAX  = 64;
  localparam logic [2:0] ADDR_TABLE_SIZE = 3'd0;

  typedef struct {
    hmpp_pkg::action_t act;
    logic [63:0]       hash;
    logic [63:0]       key;
    logic [3:0]        len;
    logic [31:0]       value;
  } req_t;

  typedef struct {
    hmpp_pkg::status_t status;
    logic [31:0]       value;
    logic [10:0]       used;
  } resp_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic [1:0]   in_tuser = '0;
  // in_tdata: key_hash, key_bytes, key_length, value_in, zero pad
  logic [167:0] in_tdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  // out_tuser: status
  logic [2:0]   out_tuser;
  // out_tdata: value_out, entries_used, zero pad
  logic [47:0]  out_tdata;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [2:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  hash_map_perturb_probe_core #(
    .MAX_SLOTS   (MAX_SLOTS),
    .MIN_SLOTS   (MIN_SLOTS),
    .PROBE_LIMIT (PROBE_LIMIT)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tuser   (out_tuser),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #1 clk = ~clk;

  // table shadow
  logic [3:0]  size_log2 = 4'd3;
  bit          tbl_valid [MAX_SLOTS];
  logic [63:0] tbl_key [MAX_SLOTS];
  logic [3:0]  tbl_len [MAX_SLOTS];
  logic [31:0] tbl_val [MAX_SLOTS];
  int          tbl_count = 0;

  // keys that random traffic keeps coming back to
  logic [63:0] pool_hash [POOL_DEPTH];
  logic [63:0] pool_key [POOL_DEPTH];
  logic [3:0]  pool_len [POOL_DEPTH];
  int          pool_n = 0;

  resp_t       expected_responses[$];
  resp_t       head_expected;
  int          send_gap_pct = 0;
  int          recv_stall_pct = 0;
  int          pricey_left = 24;
  int          fail_count = 0;
  int          requests_sent = 0;
  int          status_seen [8];
  int unsigned cycle_count = 0;

  function automatic int table_slots();
    int n;
    n = 1 << size_log2;
    if (n < MIN_SLOTS) n = MIN_SLOTS;
    if (n > MAX_SLOTS) n = MAX_SLOTS;
    return n;
  endfunction

  function automatic logic [3:0] clamp_len(input logic [3:0] len);
    if (len > 4'(hmpp_pkg::KEY_BYTES)) return 4'(hmpp_pkg::KEY_BYTES);
    return len;
  endfunction

  function automatic logic [63:0] low_bytes_mask(input int nbytes);
    if (nbytes >= 8) return '1;
    return (64'd1 << (8 * nbytes)) - 64'd1;
  endfunction

  // equal bytes up to len; a zero byte in both keys ends it as a match
  function automatic bit keys_agree(input logic [63:0] a, input logic [63:0] b,
                                    input logic [3:0] len);
    int i;
    for (i = 0; i < int'(len); i++) begin
      if (a[8*i +: 8] != b[8*i +: 8]) return 1'b0;
      if (a[8*i +: 8] == 8'h00) return 1'b1;
    end
    return 1'b1;
  endfunction

  // walks the probe chain without touching the table; stop_slot < 0 at the limit
  function automatic int probe_walk(input logic [63:0] hash, input logic [63:0] key,
                                    input logic [3:0] len, output int stop_slot,
                                    output bit matched);
    logic [63:0] j;
    logic [63:0] p;
    logic [63:0] mask;
    int n;
    int s;
    mask = 64'(table_slots() - 1);
    j = hash;
    p = hash;
    stop_slot = -1;
    matched = 1'b0;
    for (n = 0; n < PROBE_LIMIT; n++) begin
      s = int'(j & mask);
      if (!tbl_valid[s]) begin
        stop_slot = s;
        return n + 1;
      end
      if (tbl_len[s] == len && keys_agree(key, tbl_key[s], len)) begin
        stop_slot = s;
        matched = 1'b1;
        return n + 1;
      end
      j = (j * 64'd5) + 64'd1 + p;
      p = {{hmpp_pkg::PERT_SHIFT{p[63]}}, p[63:hmpp_pkg::PERT_SHIFT]};
    end
    return PROBE_LIMIT;
  endfunction

  function automatic resp_t predict_table_response(input req_t r);
    resp_t e;
    logic [3:0] len;
    int slot;
    bit matched;
    e.status = hmpp_pkg::STS_MISSING;
    e.value = '0;
    len = clamp_len(r.len);
    if (r.act == hmpp_pkg::ACT_CLEAR) begin
      foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
      tbl_count = 0;
      e.status = hmpp_pkg::STS_CLEARED;
    end else if (r.act == hmpp_pkg::ACT_INSERT || r.act == hmpp_pkg::ACT_LOOKUP) begin
      void'(probe_walk(r.hash, r.key, len, slot, matched));
      if (slot < 0) begin
        if (r.act == hmpp_pkg::ACT_INSERT) e.status = hmpp_pkg::STS_FULL;
      end else if (matched) begin
        if (r.act == hmpp_pkg::ACT_INSERT) begin
          tbl_val[slot] = r.value;
          e.status = hmpp_pkg::STS_UPDATED;
        end else begin
          e.value = tbl_val[slot];
          e.status = hmpp_pkg::STS_HIT;
        end
      end else if (r.act == hmpp_pkg::ACT_INSERT) begin
        tbl_valid[slot] = 1'b1;
        tbl_key[slot] = r.key;
        tbl_len[slot] = len;
        tbl_val[slot] = r.value;
        tbl_count++;
        e.status = hmpp_pkg::STS_INSERTED;
      end
    end
    e.used = tbl_count[10:0];
    return e;
  endfunction

  function automatic req_t request_of(input hmpp_pkg::action_t act,
                                      input logic [63:0] hash,
                                      input logic [63:0] key, input logic [3:0] len,
                                      input logic [31:0] value);
    req_t r;
    r.act = act;
    r.hash = hash;
    r.key = key;
    r.len = len;
    r.value = value;
    return r;
  endfunction

  function automatic int new_pool_key();
    int idx;
    int roll;
    logic [3:0] len;
    logic [63:0] key;
    logic [63:0] hash;
    len = 4'($urandom_range(0, 8));
    key = {$urandom(), $urandom()};
    if ($urandom_range(0, 99) < 80) key = key & low_bytes_mask(int'(len));
    if (len > 0 && $urandom_range(0, 99) < 25)
      key[8*$urandom_range(0, int'(len) - 1) +: 8] = 8'h00;
    roll = $urandom_range(0, 99);
    hash = {$urandom(), $urandom()};
    if (pool_n > 0 && roll < 20) begin
      hash = pool_hash[$urandom_range(0, pool_n - 1)];
    end else if (pool_n > 0 && roll < 35) begin
      hash[9:0] = pool_hash[$urandom_range(0, pool_n - 1)][9:0];
    end else if (roll < 45) begin
      case ($urandom_range(0, 3))
        0: hash = 64'h0;
        1: hash = '1;
        2: hash = 64'h8000_0000_0000_0000;
        default: hash = 64'h7FFF_FFFF_FFFF_FFFF;
      endcase
    end
    if (pool_n < POOL_DEPTH) begin
      idx = pool_n;
      pool_n++;
    end else begin
      idx = $urandom_range(0, POOL_DEPTH - 1);
    end
    pool_hash[idx] = hash;
    pool_key[idx] = key;
    pool_len[idx] = len;
    return idx;
  endfunction

  function automatic req_t random_request();
    req_t r;
    int roll;
    int idx;
    int i;
    int zpos;
    r = request_of(hmpp_pkg::ACT_LOOKUP, {$urandom(), $urandom()}, {$urandom(), $urandom()},
                   4'($urandom_range(0, 15)), $urandom());
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      r.act = hmpp_pkg::ACT_CLEAR;
    end else if (roll < 5) begin
      r.act = hmpp_pkg::ACT_RSVD;
    end else if (roll < 90) begin
      if (roll < 47) r.act = hmpp_pkg::ACT_INSERT;
      if (pool_n == 0 ||
          $urandom_range(0, 99) < ((r.act == hmpp_pkg::ACT_INSERT) ? 30 : 15))
        idx = new_pool_key();
      else
        idx = $urandom_range(0, pool_n - 1);
      r.hash = pool_hash[idx];
      r.key = pool_key[idx];
      r.len = pool_len[idx];
      if (r.act == hmpp_pkg::ACT_LOOKUP) begin
        roll = $urandom_range(0, 99);
        if (roll < 20) begin
          // bytes past a shared zero byte do not take part in the compare
          zpos = -1;
          for (i = 0; i < int'(r.len); i++)
            if (zpos < 0 && r.key[8*i +: 8] == 8'h00) zpos = i;
          if (zpos >= 0)
            r.key = (r.key & low_bytes_mask(zpos + 1)) |
                    ({$urandom(), $urandom()} & ~low_bytes_mask(zpos + 1));
        end else if (roll < 30) begin
          if (r.len == 0 || $urandom_range(0, 1) == 1) r.len = r.len + 4'd1;
          else r.len = r.len - 4'd1;
        end
      end
    end else begin
      r.act = hmpp_pkg::action_t'($urandom_range(0, 1));
    end
    return r;
  endfunction

  task automatic push_request(input req_t r);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= r.act;
    in_tdata <= {4'h0, r.value, r.len, r.key, r.hash};
    do @(posedge clk); while (!in_tready);
    expected_responses.push_back(predict_table_response(r));
    requests_sent++;
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_results_drained();
    while (expected_responses.size() != 0) @(posedge clk);
  endtask

  task automatic wait_block_idle();
    idle_input();
    wait_results_drained();
    while (!in_tready) @(posedge clk);
  endtask

  task automatic write_table_size(input logic [3:0] code, input bit junk_high);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= ADDR_TABLE_SIZE;
    cfg_pwdata <= {junk_high ? 28'($urandom()) : 28'h0, code};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    size_log2 = code;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // insert, update, lookup, reserved action and the hash extremes at reset size
  task automatic test_basic_ops();
    push_request(request_of(hmpp_pkg::ACT_LOOKUP, 64'h0, 64'h0, 4'd0, 32'h0));
    push_request(request_of(hmpp_pkg::ACT_INSERT, 64'h0, '1, 4'd8, 32'hFFFF_FFFF));
    push_request(request_of(hmpp_pkg::ACT_INSERT, 64'h0, '1, 4'd8, 32'h0));
    push_request(request_of(hmpp_pkg::ACT_LOOKUP, 64'h0, '1, 4'd8, 32'h0));
    push_request(request_of(hmpp_pkg::ACT_INSERT, 64'h0, 64'h63_6261, 4'd3, 32'h5A5A_5A5A));
    push_request(request_of(hmpp_pkg::ACT_LOOKUP, 64'h0, 64'h63_6261, 4'd4, 32'h0));
    push_request(request_of(hmpp_pkg::ACT_RSVD, '1, '1, 4'hF, '1));
    push_request(request_of(hmpp_pkg::ACT_INSERT, 64'h8000_0000_0000_0000, 64'h1, 4'd1,
                            32'h1));
    push_request(request_of(hmpp_pkg::ACT_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 64'h2, 4'd1,
                            32'h2));
  endtask

  // zero-byte termination, length saturation, zero-length keys
  task automatic test_key_match_rules();
    push_request(request_of(hmpp_pkg::ACT_INSERT, 64'd5, 64'h0000_0000_0011_0041, 4'd4,
                            32'h1234_5678));
    push_request(request_of(hmpp_pkg::ACT_LOOKUP, 64'd5, 64'hFFFF_FFFF_3322_0041, 4'd4,
                            32'h0));
    push_request(request_of(hmpp_pkg::ACT_LOOKUP, 64'd5, 64'h0000_0000_0011_0042, 4'd4,
                            32'h0));
    push_request(request_of(hmpp_pkg::ACT_INSERT, 64'd9, 64'hDEAD_BEEF_0102_0304, 4'd15,
                            32'h8765_4321));
    push_request(request_of(hmpp_pkg::ACT_LOOKUP, 64'd9, 64'hDEAD_BEEF_0102_0304, 4'd9,
                            32'h0));
    push_request(request_of(hmpp_pkg::ACT_INSERT, 64'd9, {$urandom(), $urandom()}, 4'd0,
                            $urandom()));
    push_request(request_of(hmpp_pkg::ACT_LOOKUP, 64'd9, {$urandom(), $urandom()}, 4'd0,
                            32'h0));
  endtask

  // fill the 8-slot table, run insert and lookup into the probe limit, then clear
  task automatic test_probe_limit();
    int k;
    for (k = 0; k < 16 && tbl_count < table_slots(); k++)
      push_request(request_of(hmpp_pkg::ACT_INSERT, 64'(k * 37),
                              {32'($urandom()), 24'h0, 8'h80 + 8'(k)}, 4'd8, $urandom()));
    push_request(request_of(hmpp_pkg::ACT_INSERT, 64'h1F, 64'h00C0_FFEE_0000_00F0, 4'd8,
                            32'hA5A5_A5A5));
    push_request(request_of(hmpp_pkg::ACT_LOOKUP, 64'h1F, 64'h00C0_FFEE_0000_00F0, 4'd8,
                            32'h0));
    push_request(request_of(hmpp_pkg::ACT_CLEAR, '1, '1, 4'hF, '1));
    push_request(request_of(hmpp_pkg::ACT_LOOKUP, 64'h0, '1, 4'd8, 32'h0));
  endtask

  task automatic test_random_traffic(input logic [3:0] size_code, input bit junk_high,
                                     input int gap, input int stall, input int count);
    req_t r;
    int k;
    int probes;
    int slot;
    bit matched;
    wait_block_idle();
    write_table_size(size_code, junk_high);
    send_gap_pct = gap;
    recv_stall_pct = stall;
    for (k = 0; k < count; k++) begin
      r = random_request();
      if (r.act == hmpp_pkg::ACT_INSERT || r.act == hmpp_pkg::ACT_LOOKUP) begin
        probes = probe_walk(r.hash, r.key, clamp_len(r.len), slot, matched);
        // long chains (over PRICEY_MAX probes) are costly; only a few are let through
        if (probes > PRICEY_MAX) begin
          if (pricey_left > 0) pricey_left--;
          else r.act = hmpp_pkg::ACT_CLEAR;
        end else if (r.act == hmpp_pkg::ACT_INSERT && slot >= 0 && !matched &&
                     tbl_count * 4 >= table_slots() * 3) begin
          r.act = hmpp_pkg::ACT_CLEAR;
        end
      end
      if (k == count / 2) begin
        idle_input();
        wait_results_drained();
      end
      push_request(r);
    end
  endtask

  always @(negedge clk) out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

  always @(posedge clk) cycle_count <= cycle_count + 1;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (!$isunknown(out_tuser)) status_seen[out_tuser]++;
      if (expected_responses.size() == 0) begin
        if (fail_count < 10)
          $display("ERROR: result with no request pending: status %0d data %h",
                   out_tuser, out_tdata);
        fail_count++;
      end else begin
        head_expected = expected_responses.pop_front();
        if (out_tuser !== head_expected.status || out_tdata[31:0] !== head_expected.value ||
            out_tdata[42:32] !== head_expected.used) begin
          if (fail_count < 10)
            $display("ERROR: t=%0t status %0d/%0d value %h/%h entries %0d/%0d (exp/got)",
                     $time, head_expected.status, out_tuser, head_expected.value,
                     out_tdata[31:0], head_expected.used, out_tdata[42:32]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    send_gap_pct = 22;
    recv_stall_pct = 70;
    test_basic_ops();
    test_key_match_rules();
    test_probe_limit();

    test_random_traffic(4'd10, 1'b0, 22, 70, 237);
    test_random_traffic(4'd0,  1'b1, 22, 70, 237);
    test_random_traffic(4'd15, 1'b0, 70, 22, 237);
    test_random_traffic(4'd5,  1'b1, 70, 22, 237);
    test_random_traffic(4'd3,  1'b0, 0, 0, 237);
    test_random_traffic(4'd7,  1'b0, 0, 0, 237);

    idle_input();
    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Summary: %0d requests; %0d new, %0d updated, %0d hits, %0d missing",
             requests_sent, status_seen[hmpp_pkg::STS_INSERTED],
             status_seen[hmpp_pkg::STS_UPDATED], status_seen[hmpp_pkg::STS_HIT],
             status_seen[hmpp_pkg::STS_MISSING]);
    $display("Summary: %0d full at probe limit, %0d clears, sizes 8..1024, %0d errors",
             status_seen[hmpp_pkg::STS_FULL], status_seen[hmpp_pkg::STS_CLEARED],
             fail_count);
    if (fail_count == 0 && expected_responses.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
